// ===== sv/mi_pkg.sv =====
// Shared types and constants for the modular inverse block.
package mi_pkg;

   localparam logic [1:0] ST_FOUND   = 2'd0;
   localparam logic [1:0] ST_NOINV   = 2'd1;
   localparam logic [1:0] ST_MODZERO = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALIGN,
      S_SUB,
      S_SWAP,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic align_step;
      logic sub_step;
      logic swap;
   } core_ctrl_type;

   typedef struct packed {
      logic can_align;
      logic k_zero;
      logic rem_zero;
      logic r0_one;
   } core_flags_type;

endpackage

// ===== sv/mi_core.sv =====
// Remainder and coefficient registers with the shift-subtract Euclid step.
module mi_core #(
   parameter int WIDTH = 32
) (
   input  logic                   clock,
   input  mi_pkg::core_ctrl_type  ctrl,
   input  logic [WIDTH-1:0]       load_value,
   input  logic [WIDTH-1:0]       load_modulus,
   output mi_pkg::core_flags_type flags,
   output logic [WIDTH-1:0]       t0_out,
   output logic                   neg0_out,
   output logic [WIDTH-1:0]       modulus_out
);

   localparam int KW = $clog2(WIDTH);

   logic [WIDTH-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic [WIDTH-1:0] t0_ff, t0_in, t1_ff, t1_in;
   logic [WIDTH-1:0] s_ff, s_in, st_ff, st_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [KW-1:0]    k_ff, k_in;
   logic             neg0_ff, neg0_in, neg1_ff, neg1_in;
   logic [WIDTH:0]   s_dbl;
   logic             s_fits;

   // Doubling of the shifted divisor, one bit wider so it cannot wrap.
   assign s_dbl  = {s_ff, 1'b0};
   assign s_fits = (s_ff <= r0_ff);

   always_comb begin
      r0_in   = r0_ff;
      r1_in   = r1_ff;
      t0_in   = t0_ff;
      t1_in   = t1_ff;
      s_in    = s_ff;
      st_in   = st_ff;
      m_in    = m_ff;
      k_in    = k_ff;
      neg0_in = neg0_ff;
      neg1_in = neg1_ff;
      if (ctrl.load) begin
         r0_in   = load_modulus;
         r1_in   = load_value;
         t0_in   = '0;
         t1_in   = {{(WIDTH-1){1'b0}}, 1'b1};
         s_in    = load_value;
         st_in   = {{(WIDTH-1){1'b0}}, 1'b1};
         m_in    = load_modulus;
         k_in    = '0;
         neg0_in = 1'b0;
         neg1_in = 1'b0;
      end else if (ctrl.align_step) begin
         s_in  = {s_ff[WIDTH-2:0], 1'b0};
         st_in = {st_ff[WIDTH-2:0], 1'b0};
         k_in  = k_ff + 1'b1;
      end else if (ctrl.sub_step) begin
         if (s_fits) begin
            r0_in = r0_ff - s_ff;
            t0_in = t0_ff + st_ff;
         end
         if (k_ff != '0) begin
            s_in  = {1'b0, s_ff[WIDTH-1:1]};
            st_in = {1'b0, st_ff[WIDTH-1:1]};
            k_in  = k_ff - 1'b1;
         end
      end else if (ctrl.swap) begin
         r0_in   = r1_ff;
         r1_in   = r0_ff;
         t0_in   = t1_ff;
         t1_in   = t0_ff;
         s_in    = r0_ff;
         st_in   = t0_ff;
         neg0_in = neg1_ff;
         neg1_in = ~neg1_ff;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      t0_ff   <= t0_in;
      t1_ff   <= t1_in;
      s_ff    <= s_in;
      st_ff   <= st_in;
      m_ff    <= m_in;
      k_ff    <= k_in;
      neg0_ff <= neg0_in;
      neg1_ff <= neg1_in;
   end

   assign flags.can_align = (s_dbl <= {1'b0, r0_ff});
   assign flags.k_zero    = (k_ff == '0);
   assign flags.rem_zero  = (r0_ff == '0);
   assign flags.r0_one    = (r0_ff == {{(WIDTH-1){1'b0}}, 1'b1});
   assign t0_out          = t0_ff;
   assign neg0_out        = neg0_ff;
   assign modulus_out     = m_ff;

endmodule

// ===== sv/modular_inverse.sv =====
// Top level of the modular inverse block: sequencer, result register and ports.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  req_value, req_modulus
//   rsp       out         rsp_valid / rsp_stall  rsp_inverse_out, rsp_status
//
// Each quotient is found by shift and subtract: align doubles the divisor while
// the double stays within the remainder, subtract takes each shifted divisor
// that fits off the remainder while halving it back, and a swap ends the step.
// After the last swap the sequencer waits in finish until the output is free.
// Time grows with the Euclid steps, most for consecutive Fibonacci numbers. A zero
// value or zero modulus is answered the cycle after it is accepted. Reset clears
// the sequencer and the result valid flag. New transactions wait while the
// sequencer is busy or a stalled result is held; the sequencer then holds in
// its last state until the output register frees.
module modular_inverse #(
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value,
   input  logic [31:0] req_modulus,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_inverse_out,
   output logic [1:0]  rsp_status
);

   localparam int FW = 32;

   mi_pkg::state_type      state_ff, state_in;
   mi_pkg::core_ctrl_type  ctrl;
   mi_pkg::core_flags_type flags;

   logic [WIDTH-1:0] value_w, modulus_w;
   logic [WIDTH-1:0] t0, modulus;
   logic             neg0;
   logic [WIDTH-1:0] t_red, inv;
   logic [FW-1:0]    inv_field;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]    rsp_inv_ff, rsp_inv_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             out_free;
   logic             req_take;

   // Fit the 32-bit fields to the datapath width and back.
   generate
      if (WIDTH > FW) begin : g_wide
         assign value_w   = {{(WIDTH-FW){1'b0}}, req_value};
         assign modulus_w = {{(WIDTH-FW){1'b0}}, req_modulus};
         assign inv_field = inv[FW-1:0];
      end else if (WIDTH == FW) begin : g_same
         assign value_w   = req_value;
         assign modulus_w = req_modulus;
         assign inv_field = inv;
      end else begin : g_narrow
         assign value_w   = req_value[WIDTH-1:0];
         assign modulus_w = req_modulus[WIDTH-1:0];
         assign inv_field = {{(FW-WIDTH){1'b0}}, inv};
      end
   endgenerate

   mi_core #(.WIDTH(WIDTH)) u_core (
      .clock        (clock),
      .ctrl         (ctrl),
      .load_value   (value_w),
      .load_modulus (modulus_w),
      .flags        (flags),
      .t0_out       (t0),
      .neg0_out     (neg0),
      .modulus_out  (modulus)
   );

   // The coefficient never exceeds the modulus, so one conditional subtract
   // reduces it, and a negative coefficient is folded into range.
   assign t_red = (t0 >= modulus) ? (t0 - modulus) : t0;
   assign inv   = (neg0 && (t_red != '0)) ? (modulus - t_red) : t_red;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != mi_pkg::S_IDLE) || !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      ctrl          = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_inv_in    = rsp_inv_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         mi_pkg::S_IDLE: begin
            if (req_take) begin
               if (modulus_w == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_inv_in    = '0;
                  rsp_status_in = mi_pkg::ST_MODZERO;
               end else if (value_w == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_inv_in    = '0;
                  rsp_status_in = mi_pkg::ST_NOINV;
               end else begin
                  ctrl.load = 1'b1;
                  state_in  = mi_pkg::S_ALIGN;
               end
            end
         end
         mi_pkg::S_ALIGN: begin
            if (flags.can_align) begin
               ctrl.align_step = 1'b1;
            end else begin
               state_in = mi_pkg::S_SUB;
            end
         end
         mi_pkg::S_SUB: begin
            ctrl.sub_step = 1'b1;
            if (flags.k_zero) begin
               state_in = mi_pkg::S_SWAP;
            end
         end
         mi_pkg::S_SWAP: begin
            // The remainder just formed sits in r0; zero ends the loop.
            ctrl.swap = 1'b1;
            state_in  = flags.rem_zero ? mi_pkg::S_FINISH : mi_pkg::S_ALIGN;
         end
         mi_pkg::S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = mi_pkg::S_IDLE;
               if (flags.r0_one) begin
                  rsp_inv_in    = inv_field;
                  rsp_status_in = mi_pkg::ST_FOUND;
               end else begin
                  rsp_inv_in    = '0;
                  rsp_status_in = mi_pkg::ST_NOINV;
               end
            end
         end
         default: begin
            state_in = mi_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mi_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_inv_ff    <= rsp_inv_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_inverse_out = rsp_inv_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ===== tb/modular_inverse_test.sv =====
// Self-checking testbench for the modular inverse block.
`timescale 1ns / 100ps

module modular_inverse_test;

   typedef struct {
      logic [31:0] value;
      logic [31:0] modulus;
   } operand_pair_type;

   typedef struct {
      logic [31:0] inverse;
      logic [1:0]  status;
   } inverse_result_type;

   localparam int CYCLE_LIMIT = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_value = '0;
   logic [31:0] req_modulus = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_inverse_out;
   logic [1:0]  rsp_status;

   operand_pair_type   pending_pairs[$];
   inverse_result_type expected_inverses[$];
   int                 send_idle_pct = 16;
   int                 recv_idle_pct = 55;
   int                 error_count = 0;
   int                 cycle_count = 0;

   modular_inverse dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_value(req_value), .req_modulus(req_modulus),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_inverse_out(rsp_inverse_out), .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   // Extended Euclid on 64-bit scratch values; coefficient magnitudes stay at
   // or below the modulus, so nothing here can overflow.
   function automatic inverse_result_type predict_inverse(operand_pair_type p);
      inverse_result_type res;
      logic [63:0] r0, r1, r2, t0, t1, t2, q, m;
      bit neg0, neg1;
      res.inverse = '0;
      m = p.modulus;
      if (p.modulus == 0) begin
         res.status = mi_pkg::ST_MODZERO;
         return res;
      end
      if (p.value == 0) begin
         res.status = mi_pkg::ST_NOINV;
         return res;
      end
      r0 = m;
      r1 = p.value % m;
      t0 = 0;
      t1 = 1;
      neg0 = 1'b0;
      neg1 = 1'b0;
      while (r1 != 0) begin
         q = r0 / r1;
         r2 = r0 - q * r1;
         t2 = t0 + q * t1;
         r0 = r1;
         r1 = r2;
         t0 = t1;
         t1 = t2;
         neg0 = neg1;
         neg1 = ~neg1;
      end
      if (r0 != 1) begin
         res.status = mi_pkg::ST_NOINV;
         return res;
      end
      t0 = t0 % m;
      if (neg0 && t0 != 0) t0 = m - t0;
      res.inverse = 32'(t0 % m);
      res.status = mi_pkg::ST_FOUND;
      return res;
   endfunction

   function automatic logic [31:0] random_word();
      // Mix full-range words with small ones so short Euclid runs also appear.
      case ($urandom_range(3))
         0: return $urandom_range(255);
         1: return $urandom_range(65535);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_pair(logic [31:0] v, logic [31:0] m);
      operand_pair_type p;
      p.value = v;
      p.modulus = m;
      pending_pairs.push_back(p);
   endtask

   // The driver holds the payload steady while the block stalls and only
   // loads the next transaction once the current one is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            operand_pair_type p;
            p = pending_pairs.pop_front();
            req_valid <= 1'b1;
            req_value <= p.value;
            req_modulus <= p.modulus;
            expected_inverses.push_back(predict_inverse(p));
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The monitor checks each accepted result against the oldest expectation
   // and draws the stall for the next cycle.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_inverses.size() == 0) begin
               $error("result with no transaction outstanding: inverse %0d status %0d",
                      rsp_inverse_out, rsp_status);
               error_count++;
            end else begin
               inverse_result_type e;
               e = expected_inverses.pop_front();
               if (rsp_inverse_out !== e.inverse) begin
                  $error("inverse_out: expected %0d, actual %0d", e.inverse, rsp_inverse_out);
                  error_count++;
               end
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, actual %0d", e.status, rsp_status);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Timeout guard over all 711 transactions, also under heavy stalling.
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("modular_inverse regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed cases: zero modulus, zero value, modulus one, value above the
      // modulus, non-coprime pairs and the extremes of both fields.
      queue_pair(32'd5, 32'd0);
      queue_pair(32'd0, 32'd0);
      queue_pair(32'hFFFF_FFFF, 32'd0);
      queue_pair(32'd0, 32'd7);
      queue_pair(32'd0, 32'd1);
      queue_pair(32'd9, 32'd1);
      queue_pair(32'hFFFF_FFFF, 32'd1);
      queue_pair(32'd3, 32'd7);
      queue_pair(32'd10, 32'd7);
      queue_pair(32'd6, 32'd9);
      queue_pair(32'd1, 32'd2);
      queue_pair(32'd1, 32'hFFFF_FFFF);
      queue_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      queue_pair(32'h8000_0000, 32'hFFFF_FFFF);
      queue_pair(32'd3, 32'h8000_0000);
      queue_pair(32'h8000_0000, 32'h8000_0000);
      queue_pair(32'hB504_F333, 32'hFFFF_FFFB);
      queue_pair(32'd2971215073, 32'd1836311903);
      queue_pair(32'd1836311903, 32'd2971215073);
      queue_pair(32'h5555_5555, 32'hAAAA_AAAA);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 55 : 0;
         recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 16 : 0;
         for (int i = 0; i < 230; i++) begin
            logic [31:0] v, m;
            v = random_word();
            m = random_word();
            // Odd moduli give far more inverses; keep some even ones too.
            if ($urandom_range(3) != 0) m[0] = 1'b1;
            if ($urandom_range(19) == 0) v = 32'd0;
            if ($urandom_range(19) == 0) m = 32'd0;
            queue_pair(v, m);
         end
         wait (pending_pairs.size() == 0 && expected_inverses.size() == 0);
         @(posedge clock);
      end

      wait (!req_valid && expected_inverses.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("modular_inverse regression: pass");
      end else begin
         $display("modular_inverse regression: fail");
      end
      $finish;
   end

endmodule

// ===== modular_inverse.f =====
sv/mi_pkg.sv
sv/mi_core.sv
sv/modular_inverse.sv
tb/modular_inverse_test.sv
